[rtl/core/tmhc_pkg.sv]
// tmhc_pkg: types and constants for the tunnel message header check
// holds the request and verdict payload structs, error codes, type codes and register map
// no dependencies

package tmhc_pkg;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_MISSING = 2'd1,
        ERR_UNKNOWN = 2'd2,
        ERR_LENGTH  = 2'd3
    } err_code_t;

    typedef enum logic [1:0] {
        REG_INITIATION_LENGTH = 2'd0,
        REG_RESPONSE_LENGTH   = 2'd1,
        REG_COOKIE_LENGTH     = 2'd2,
        REG_TRANSPORT_LENGTH  = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_BITS = 16;

    // message type codes as they appear in the little-endian type word
    localparam logic [31:0] TYPE_INITIATION = 32'd1;
    localparam logic [31:0] TYPE_RESPONSE   = 32'd2;
    localparam logic [31:0] TYPE_COOKIE     = 32'd3;
    localparam logic [31:0] TYPE_TRANSPORT  = 32'd4;

    // register reset values
    localparam logic [CFG_BITS-1:0] INITIATION_LENGTH_RST = 16'd148;
    localparam logic [CFG_BITS-1:0] RESPONSE_LENGTH_RST   = 16'd92;
    localparam logic [CFG_BITS-1:0] COOKIE_LENGTH_RST     = 16'd64;
    localparam logic [CFG_BITS-1:0] TRANSPORT_LENGTH_RST  = 16'd16;

    // bytes covered by the fields each type reports
    localparam logic [CFG_BITS-1:0] INITIATION_FIELD_BYTES = 16'd8;
    localparam logic [CFG_BITS-1:0] RESPONSE_FIELD_BYTES   = 16'd12;
    localparam logic [CFG_BITS-1:0] COOKIE_FIELD_BYTES     = 16'd8;
    localparam logic [CFG_BITS-1:0] TRANSPORT_FIELD_BYTES  = 16'd16;

    localparam logic [15:0] PACKET_LENGTH_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic        accepted;
        err_code_t   error_code;
        logic [31:0] type_word;
        logic [31:0] sender_idx;
        logic [31:0] receiver_idx;
        logic [63:0] nonce_counter;
        logic [15:0] packet_length;
    } verdict_t;

endpackage

[rtl/core/tunnel_message_header_check.sv]
// the verdict is registered: verdict_valid rises in the cycle after the request carrying the last byte
// throughput: one byte request per cycle, back to back, also across packet boundaries
// the verdict sits in an output register, so bytes keep flowing unless that register is full
// and stalled
// reset: clears the byte counter, the gathered words and the output valid; length registers
// return to 148, 92, 64 and 16
//
// tunnel_message_header_check: byte-serial header parser and length checker
// depends on tmhc_pkg

module tunnel_message_header_check #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         byte_valid,
    output logic                         byte_stall,
    input  tmhc_pkg::byte_item_t         byte_data,

    output logic                         verdict_valid,
    input  logic                         verdict_stall,
    output tmhc_pkg::verdict_t           verdict_data,

    input  logic                         cfg_write_en,
    input  tmhc_pkg::cfg_index_t         cfg_index,
    input  logic [tmhc_pkg::CFG_BITS-1:0] cfg_data
);

    localparam int unsigned CMP_BITS =
        (LENGTH_BITS > tmhc_pkg::CFG_BITS) ? LENGTH_BITS : tmhc_pkg::CFG_BITS;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] COUNT_TYPE_END   = LENGTH_BITS'(4);
    localparam logic [LENGTH_BITS-1:0] COUNT_FIRST_END  = LENGTH_BITS'(8);
    localparam logic [LENGTH_BITS-1:0] COUNT_SECOND_END = LENGTH_BITS'(16);

    logic [tmhc_pkg::CFG_BITS-1:0] init_len_reg;
    logic [tmhc_pkg::CFG_BITS-1:0] resp_len_reg;
    logic [tmhc_pkg::CFG_BITS-1:0] cookie_len_reg;
    logic [tmhc_pkg::CFG_BITS-1:0] transport_len_reg;

    logic [LENGTH_BITS-1:0] count_reg,  count_next;
    logic [31:0]            type_reg,   type_next;
    logic [31:0]            first_reg,  first_next;
    logic [63:0]            second_reg, second_next;

    logic                   verdict_valid_reg, verdict_valid_next;
    tmhc_pkg::verdict_t     verdict_reg,       verdict_next;

    logic                   byte_accept;
    logic                   verdict_taken;
    logic [CMP_BITS-1:0]    count_ext;
    logic [CMP_BITS-1:0]    need_ext;
    logic [CMP_BITS-1:0]    fields_ext;
    logic [tmhc_pkg::CFG_BITS-1:0] need;
    logic [tmhc_pkg::CFG_BITS-1:0] fields_need;
    logic                   exact;
    logic                   known;
    logic                   length_ok;

    assign verdict_taken = verdict_valid_reg && !verdict_stall;
    assign byte_stall    = verdict_valid_reg && verdict_stall;
    assign byte_accept   = byte_valid && !byte_stall;
    assign verdict_valid = verdict_valid_reg;
    assign verdict_data  = verdict_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_len_reg      <= tmhc_pkg::INITIATION_LENGTH_RST;
            resp_len_reg      <= tmhc_pkg::RESPONSE_LENGTH_RST;
            cookie_len_reg    <= tmhc_pkg::COOKIE_LENGTH_RST;
            transport_len_reg <= tmhc_pkg::TRANSPORT_LENGTH_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                tmhc_pkg::REG_INITIATION_LENGTH: init_len_reg      <= cfg_data;
                tmhc_pkg::REG_RESPONSE_LENGTH:   resp_len_reg      <= cfg_data;
                tmhc_pkg::REG_COOKIE_LENGTH:     cookie_len_reg    <= cfg_data;
                tmhc_pkg::REG_TRANSPORT_LENGTH:  transport_len_reg <= cfg_data;
                default:                         init_len_reg      <= init_len_reg;
            endcase
        end
    end

    // gather the byte into its word and advance the saturating count
    always_comb
    begin
        type_next   = type_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (count_reg < COUNT_TYPE_END)
        begin
            type_next[{count_reg[1:0], 3'b000} +: 8] = byte_data.data_byte;
        end
        else if (count_reg < COUNT_FIRST_END)
        begin
            first_next[{count_reg[1:0], 3'b000} +: 8] = byte_data.data_byte;
        end
        else if (count_reg < COUNT_SECOND_END)
        begin
            second_next[{count_reg[2:0], 3'b000} +: 8] = byte_data.data_byte;
        end
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    end

    // verdict for a packet ending on this byte
    always_comb
    begin
        need        = '0;
        fields_need = '0;
        exact       = 1'b1;
        known       = 1'b1;
        unique case (type_next)
            tmhc_pkg::TYPE_INITIATION:
            begin
                need        = init_len_reg;
                fields_need = tmhc_pkg::INITIATION_FIELD_BYTES;
            end
            tmhc_pkg::TYPE_RESPONSE:
            begin
                need        = resp_len_reg;
                fields_need = tmhc_pkg::RESPONSE_FIELD_BYTES;
            end
            tmhc_pkg::TYPE_COOKIE:
            begin
                need        = cookie_len_reg;
                fields_need = tmhc_pkg::COOKIE_FIELD_BYTES;
            end
            tmhc_pkg::TYPE_TRANSPORT:
            begin
                need        = transport_len_reg;
                fields_need = tmhc_pkg::TRANSPORT_FIELD_BYTES;
                exact       = 1'b0;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase

        count_ext  = CMP_BITS'(count_next);
        need_ext   = CMP_BITS'(need);
        fields_ext = CMP_BITS'(fields_need);
        length_ok  = (exact ? (count_ext == need_ext) : (count_ext >= need_ext))
                     && (count_ext >= fields_ext);

        verdict_next                = '0;
        verdict_next.error_code     = tmhc_pkg::ERR_NONE;
        verdict_next.packet_length  = (count_ext > CMP_BITS'(tmhc_pkg::PACKET_LENGTH_MAX))
                                      ? tmhc_pkg::PACKET_LENGTH_MAX : count_ext[15:0];
        if (count_next < COUNT_TYPE_END)
        begin
            verdict_next.error_code = tmhc_pkg::ERR_MISSING;
        end
        else
        begin
            verdict_next.type_word = type_next;
            if (!known)
            begin
                verdict_next.error_code = tmhc_pkg::ERR_UNKNOWN;
            end
            else if (!length_ok)
            begin
                verdict_next.error_code = tmhc_pkg::ERR_LENGTH;
            end
            else
            begin
                verdict_next.accepted = 1'b1;
                unique case (type_next)
                    tmhc_pkg::TYPE_INITIATION:
                    begin
                        verdict_next.sender_idx = first_next;
                    end
                    tmhc_pkg::TYPE_RESPONSE:
                    begin
                        verdict_next.sender_idx   = first_next;
                        verdict_next.receiver_idx = second_next[31:0];
                    end
                    tmhc_pkg::TYPE_COOKIE:
                    begin
                        verdict_next.receiver_idx = first_next;
                    end
                    default:
                    begin
                        verdict_next.receiver_idx  = first_next;
                        verdict_next.nonce_counter = second_next;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (byte_accept && byte_data.last_byte)
        begin
            verdict_valid_next = 1'b1;
        end
        else if (verdict_taken)
        begin
            verdict_valid_next = 1'b0;
        end
        else
        begin
            verdict_valid_next = verdict_valid_reg;
        end
    end

    // packet state, cleared after each verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            type_reg   <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else if (byte_accept)
        begin
            if (byte_data.last_byte)
            begin
                count_reg  <= '0;
                type_reg   <= '0;
                first_reg  <= '0;
                second_reg <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                type_reg   <= type_next;
                first_reg  <= first_next;
                second_reg <= second_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_valid_reg <= 1'b0;
        end
        else
        begin
            verdict_valid_reg <= verdict_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept && byte_data.last_byte)
        begin
            verdict_reg <= verdict_next;
        end
    end

    // packet state starts over after the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && byte_data.last_byte) |=> (count_reg == '0) && (type_reg == '0))
        else $error("packet state not cleared after last byte");

    // count steps by one on every accepted middle byte until saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && !byte_data.last_byte && (count_reg != COUNT_MAX))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("byte count did not advance");

    // a passing verdict carries no error and a known type
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid_reg && verdict_reg.accepted)
        |-> (verdict_reg.error_code == tmhc_pkg::ERR_NONE)
            && (verdict_reg.type_word != 32'd0)
            && (verdict_reg.type_word <= tmhc_pkg::TYPE_TRANSPORT))
        else $error("accepted verdict inconsistent");

    // a missing type comes only from a packet under four bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid_reg && (verdict_reg.error_code == tmhc_pkg::ERR_MISSING))
        |-> (verdict_reg.type_word == 32'd0) && (verdict_reg.packet_length < 16'd4)
            && !verdict_reg.accepted)
        else $error("missing type verdict inconsistent");

    // a failed verdict reports no indices
    assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid_reg && !verdict_reg.accepted)
        |-> (verdict_reg.sender_idx == 32'd0) && (verdict_reg.receiver_idx == 32'd0)
            && (verdict_reg.nonce_counter == 64'd0))
        else $error("failed verdict carries fields");

endmodule
